### sv/tftp_write_receiver_assert.svh
// Assertion macros shared by the tftp_write_receiver modules.
// Each macro checks a property on the rising clock edge and is disabled in reset.
`ifndef TFTP_WRITE_RECEIVER_ASSERT_SVH
`define TFTP_WRITE_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("twr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("twr assertion failed");

`endif

### sv/twr_pkg.sv
package twr_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;

  localparam logic [15:0] OP_DATA       = 16'd3;
  localparam logic [15:0] LAST_BLOCK    = 16'hFFFF;
  localparam logic [9:0]  HDR_BYTES     = 10'd4;
  localparam logic [3:0]  MAX_TRIES_RST = 4'd10;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_PACKET = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RECV  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ABORT = 2'd3
  } status_e;

  typedef enum logic {
    ERR_NOT_DEFINED = 1'b0,
    ERR_WRONG_PEER  = 1'b1
  } err_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] src_port;
    logic [15:0] opcode;
    logic [15:0] block_num;
    logic [9:0]  pkt_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_block;
    logic        err_code;
    logic        store_payload;
    logic [9:0]  payload_len;
    logic [1:0]  status;
  } out_item_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

### sv/twr_in_if.sv
interface twr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] src_port;
  logic [15:0] opcode;
  logic [15:0] block_num;
  logic [9:0]  pkt_len;

  modport source (output valid, cmd, src_port, opcode, block_num, pkt_len, input ready);
  modport sink (input valid, cmd, src_port, opcode, block_num, pkt_len, output ready);
endinterface

### sv/twr_out_if.sv
interface twr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  send_kind;
  logic [15:0] send_block;
  logic        err_code;
  logic        store_payload;
  logic [9:0]  payload_len;
  logic [1:0]  status;

  modport source (output valid, send_kind, send_block, err_code, store_payload,
                  payload_len, status, input ready);
  modport sink (input valid, send_kind, send_block, err_code, store_payload,
                payload_len, status, output ready);
endinterface

### sv/twr_in_stage.sv
module twr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  twr_in_if.sink            in_i,
  input  logic              advance_i,
  output twr_pkg::in_item_t item_o,
  output logic              valid_o
);
  import twr_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  // A new beat can enter when the register is empty or the held one leaves in the same cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{cmd: in_i.cmd, src_port: in_i.src_port, opcode: in_i.opcode,
                  block_num: in_i.block_num, pkt_len: in_i.pkt_len};
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

### sv/twr_ctrl.sv
module twr_ctrl #(
  parameter int unsigned BLOCK_BYTES = twr_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i,
  input  twr_pkg::in_item_t   item_i,
  input  logic                valid_i,
  input  logic                slot_free_i,
  output twr_pkg::stage_ctl_t ctl_o,
  output twr_pkg::out_item_t  result_o
);
  import twr_pkg::*;

  `include "tftp_write_receiver_assert.svh"

  localparam logic [10:0] BlockLen = 11'(BLOCK_BYTES);

  logic [15:0] expected_q, expected_d;
  logic [3:0]  retry_q, retry_d;
  logic [15:0] peer_q, peer_d;
  logic        active_q, active_d;
  logic [3:0]  max_tries_q;

  logic        fire;
  logic [3:0]  retry_inc;
  logic [9:0]  plen_raw;
  logic [9:0]  plen;
  logic        done;
  out_item_t   res;

  assign fire      = valid_i && slot_free_i;
  assign retry_inc = retry_q + 4'd1;
  assign plen_raw  = item_i.pkt_len - HDR_BYTES;
  assign plen      = ({1'b0, plen_raw} > BlockLen) ? BlockLen[9:0] : plen_raw;
  assign done      = (item_i.block_num == LAST_BLOCK) || ({1'b0, plen} < BlockLen);

  always_comb begin
    expected_d = expected_q;
    retry_d    = retry_q;
    peer_d     = peer_q;
    active_d   = active_q;
    res        = '0;
    res.status = active_q ? ST_RECV : ST_IDLE;

    case (cmd_e'(item_i.cmd))
      CMD_START: begin
        peer_d        = item_i.src_port;
        expected_d    = 16'd1;
        retry_d       = 4'd0;
        active_d      = 1'b1;
        res.send_kind = KIND_ACK;
        res.status    = ST_RECV;
      end
      CMD_TICK: begin
        if (active_q) begin
          // A zero limit is reached by the first tick, as is any limit at or below the count.
          if (retry_inc >= max_tries_q) begin
            retry_d       = 4'd0;
            active_d      = 1'b0;
            res.send_kind = KIND_ERR;
            res.status    = ST_ABORT;
          end else begin
            retry_d        = retry_inc;
            res.send_kind  = KIND_ACK;
            res.send_block = expected_q - 16'd1;
          end
        end
      end
      CMD_PACKET: begin
        if (active_q) begin
          retry_d = 4'd0;
          if (item_i.src_port != peer_q) begin
            res.send_kind = KIND_ERR;
            res.err_code  = ERR_WRONG_PEER;
          end else if (item_i.opcode != OP_DATA || item_i.pkt_len < HDR_BYTES) begin
            res.send_kind = KIND_ERR;
            res.err_code  = ERR_NOT_DEFINED;
          end else if (item_i.block_num == LAST_BLOCK ||
                       item_i.block_num == expected_q) begin
            res.send_kind     = KIND_ACK;
            res.send_block    = item_i.block_num;
            res.store_payload = 1'b1;
            res.payload_len   = plen;
            if (item_i.block_num != LAST_BLOCK) begin
              expected_d = expected_q + 16'd1;
            end
            if (done) begin
              active_d   = 1'b0;
              res.status = ST_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= 16'd1;
      retry_q    <= 4'd0;
      peer_q     <= 16'd0;
      active_q   <= 1'b0;
    end else if (fire) begin
      expected_q <= expected_d;
      retry_q    <= retry_d;
      peer_q     <= peer_d;
      active_q   <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= MAX_TRIES_RST;
    end else if (cfg_we_i) begin
      max_tries_q <= cfg_data_i;
    end
  end

  assign ctl_o    = '{valid: valid_i, advance: fire};
  assign result_o = res;

  `TWR_ASSERT_SAME(a_store_acks_block, clk_i, rst_ni, fire && res.store_payload,
                   res.send_kind == KIND_ACK && res.send_block == item_i.block_num)
  `TWR_ASSERT_NEXT(a_start_opens, clk_i, rst_ni, fire && item_i.cmd == CMD_START,
                   active_q && expected_q == 16'd1 && retry_q == 4'd0)
  `TWR_ASSERT_SAME(a_idle_no_retry, clk_i, rst_ni, !active_q, retry_q == 4'd0)

endmodule

### sv/twr_out_stage.sv
module twr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  twr_pkg::out_item_t result_i,
  output logic               slot_free_o,
  twr_out_if.source          out_o
);
  import twr_pkg::*;

  `include "tftp_write_receiver_assert.svh"

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign slot_free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.send_kind     = data_q.send_kind;
  assign out_o.send_block    = data_q.send_block;
  assign out_o.err_code      = data_q.err_code;
  assign out_o.store_payload = data_q.store_payload;
  assign out_o.payload_len   = data_q.payload_len;
  assign out_o.status        = data_q.status;

  `TWR_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, load_i, !valid_q || out_o.ready)

endmodule

### sv/tftp_write_receiver.sv
// Receiving side of a TFTP write transfer, at the level of packet headers.
// in_i carries one event per beat: start of a transfer (with the client port),
// a received packet (sender port, opcode, block number, datagram length) or a
// timeout tick. out_o returns exactly one result beat per input beat: what to
// send (nothing, ACK or ERROR), the ACK block, the error code, whether and how
// many payload bytes to store, and the transfer status.
// cfg_we_i/cfg_data_i write the number of consecutive ticks that abort a
// transfer; write it only while no beat is in flight.
// The beat waits in the input register while the decision logic works on it,
// and the result register loads the outcome once out_o has a free slot, so
// a stall on out_o can hold it between the two. Throughput is one beat per
// cycle while out_o is not stalled, since the state update is a single
// compare-and-increment step between those registers.
// Reset empties both registers, leaves the block idle with the tick limit at 10
// and the expected block at 1. When out_o is stalled the result register holds
// its beat, the input register fills behind it, and in_i.ready then drops
// until out_o takes a beat.
module tftp_write_receiver #(
  parameter int unsigned BLOCK_BYTES = twr_pkg::BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  twr_in_if.sink     in_i,
  twr_out_if.source  out_o
);
  import twr_pkg::*;

  in_item_t   item;
  logic       item_valid;
  logic       slot_free;
  stage_ctl_t ctl;
  out_item_t  result;

  twr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (ctl.advance),
    .item_o    (item),
    .valid_o   (item_valid)
  );

  twr_ctrl #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .valid_i     (item_valid),
    .slot_free_i (slot_free),
    .ctl_o       (ctl),
    .result_o    (result)
  );

  twr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.advance && ctl.valid),
    .result_i    (result),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule

### tb/tftp_write_receiver_test.sv
module tftp_write_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twr_pkg::*;

  localparam int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [15:0] OP_ACK      = 16'd4;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 119;

  // Mirrors the transfer state and works out the reply to every accepted beat.
  class reply_predictor;
    logic [15:0] next_block;
    logic [3:0]  retries;
    logic [15:0] peer;
    bit          open;
    logic [3:0]  tries;
    out_item_t   expected_replies[$];
    int          events, replies, stores, completions, aborts, mismatches;

    function new();
      next_block = 16'd1;
      retries    = '0;
      peer       = '0;
      open       = 1'b0;
      tries      = MAX_TRIES_RST;
    endfunction

    function void set_tries(logic [3:0] value);
      tries = value;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t   r;
      logic [9:0]  plen;
      bit          done;
      events++;
      r = '0;
      r.send_kind = KIND_NONE;
      r.status = open ? ST_RECV : ST_IDLE;
      if (ev.cmd == CMD_START) begin
        peer = ev.src_port;
        next_block = 16'd1;
        retries = '0;
        open = 1'b1;
        r.send_kind = KIND_ACK;
        r.status = ST_RECV;
      end else if (open && ev.cmd == CMD_TICK) begin
        retries = retries + 4'd1;
        if (retries >= tries) begin
          retries = '0;
          open = 1'b0;
          r.send_kind = KIND_ERR;
          r.err_code = ERR_NOT_DEFINED;
          r.status = ST_ABORT;
        end else begin
          r.send_kind = KIND_ACK;
          r.send_block = next_block - 16'd1;
        end
      end else if (open && ev.cmd == CMD_PACKET) begin
        retries = '0;
        if (ev.src_port != peer) begin
          r.send_kind = KIND_ERR;
          r.err_code = ERR_WRONG_PEER;
        end else if (ev.opcode != OP_DATA || ev.pkt_len < HDR_BYTES) begin
          r.send_kind = KIND_ERR;
          r.err_code = ERR_NOT_DEFINED;
        end else if (ev.block_num == LAST_BLOCK || ev.block_num == next_block) begin
          plen = ev.pkt_len - HDR_BYTES;
          if (plen > BLOCK_BYTES) plen = 10'(BLOCK_BYTES);
          done = (ev.block_num == LAST_BLOCK) || (plen < BLOCK_BYTES);
          if (ev.block_num != LAST_BLOCK) next_block = next_block + 16'd1;
          if (done) open = 1'b0;
          r.send_kind = KIND_ACK;
          r.send_block = ev.block_num;
          r.store_payload = 1'b1;
          r.payload_len = plen;
          r.status = done ? ST_DONE : ST_RECV;
        end
      end
      expected_replies.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) report($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      replies++;
      if (got.store_payload === 1'b1) stores++;
      if (got.status === ST_DONE) completions++;
      if (got.status === ST_ABORT) aborts++;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply with none outstanding: kind %0h block %0h status %0h",
                         got.send_kind, got.send_block, got.status));
        return;
      end
      want = expected_replies.pop_front();
      compare_field("send_kind", 16'(want.send_kind), 16'(got.send_kind));
      compare_field("send_block", want.send_block, got.send_block);
      compare_field("err_code", 16'(want.err_code), 16'(got.err_code));
      compare_field("store_payload", 16'(want.store_payload), 16'(got.store_payload));
      compare_field("payload_len", 16'(want.payload_len), 16'(got.payload_len));
      compare_field("status", 16'(want.status), 16'(got.status));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_data_i;

  twr_in_if  in_if();
  twr_out_if out_if();

  tftp_write_receiver i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  reply_predictor predictor = new();

  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          cur_tries     = MAX_TRIES_RST;
  bit          gen_open      = 1'b0;
  logic [15:0] gen_port      = '0;
  logic [15:0] gen_next      = 16'd1;
  int          gen_ticks     = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predictor.note_event(in_item_t'{in_if.cmd, in_if.src_port, in_if.opcode,
                                        in_if.block_num, in_if.pkt_len});
      end
      if (out_if.valid && out_if.ready) begin
        predictor.check_reply(out_item_t'{out_if.send_kind, out_if.send_block,
                                          out_if.err_code, out_if.store_payload,
                                          out_if.payload_len, out_if.status});
      end
    end
  end

  task automatic send_event(in_item_t ev);
    if ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= ev.cmd;
    in_if.src_port  <= ev.src_port;
    in_if.opcode    <= ev.opcode;
    in_if.block_num <= ev.block_num;
    in_if.pkt_len   <= ev.pkt_len;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // The extra edge first lets the monitor record the beat accepted last.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (predictor.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [3:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_tries = value;
    predictor.set_tries(value);
  endtask

  function automatic in_item_t make_event(logic [1:0] cmd, logic [15:0] port,
                                          logic [15:0] op, logic [15:0] blk,
                                          logic [9:0] len);
    return in_item_t'{cmd, port, op, blk, len};
  endfunction

  // Mostly in-order transfers with random content, mixed with protocol errors,
  // timeouts, restarts and plain noise.
  function automatic in_item_t random_event();
    in_item_t ev;
    int       r;
    ev = make_event(CMD_PACKET, gen_port, OP_DATA, gen_next, 10'd516);
    r = $urandom_range(99);
    if (!gen_open) r = (r < 70) ? 93 : 99;
    if (r < 55) begin
      if ($urandom_range(99) < 12) ev.pkt_len = 10'($urandom_range(515, 4));
      else if ($urandom_range(99) < 4) ev.pkt_len = 10'($urandom_range(1023, 517));
      gen_next = gen_next + 16'd1;
      if (ev.pkt_len < 10'd516) gen_open = 1'b0;
    end else if (r < 62) begin
      ev.block_num = $urandom_range(1) ? gen_next - 16'd1 : 16'($urandom);
      if (ev.block_num == gen_next || ev.block_num == LAST_BLOCK)
        ev.block_num = gen_next + 16'd1;
      ev.pkt_len = 10'($urandom_range(1023, 4));
    end else if (r < 68) begin
      ev.src_port = gen_port ^ 16'($urandom_range(65535, 1));
    end else if (r < 73) begin
      ev.opcode = 16'($urandom);
      if (ev.opcode == OP_DATA) ev.opcode = OP_ACK;
    end else if (r < 77) begin
      ev.pkt_len = 10'($urandom_range(3));
    end else if (r < 87) begin
      ev.cmd = CMD_TICK;
    end else if (r < 89) begin
      ev.block_num = LAST_BLOCK;
      ev.pkt_len = 10'($urandom_range(1023, 4));
      gen_open = 1'b0;
    end else if (r < 92) begin
      ev = make_event(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                      10'($urandom));
    end else if (r < 96) begin
      ev.cmd = CMD_START;
      ev.src_port = 16'($urandom);
    end else begin
      ev = make_event(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      10'($urandom));
    end
    if (ev.cmd == CMD_START) begin
      gen_open = 1'b1;
      gen_next = 16'd1;
      gen_ticks = 0;
      gen_port = ev.src_port;
    end else if (ev.cmd == CMD_TICK && gen_open) begin
      gen_ticks++;
      if (gen_ticks >= cur_tries) begin
        gen_open = 1'b0;
        gen_ticks = 0;
      end
    end else if (ev.cmd == CMD_PACKET) begin
      gen_ticks = 0;
    end
    return ev;
  endfunction

  initial begin
    in_item_t    directed[$];
    in_item_t    ev;
    int          n;
    int          idle_in[4]  = '{0, 65, 0, 12};
    int          stall_out[4] = '{0, 0, 65, 12};
    logic [3:0]  tries_seq[PHASES] = '{4'd15, 4'd1, 4'd0, 4'd10, 4'd7, 4'd15, 4'd2, 4'd12};

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_START;
    in_if.src_port  = '0;
    in_if.opcode    = '0;
    in_if.block_num = '0;
    in_if.pkt_len   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting(4'd3);
    // Idle beats first, then one transfer through every packet check, a
    // restart, a last-block finish and an abort on consecutive timeouts.
    directed = '{
      make_event(CMD_TICK,   16'h0000, OP_DATA, 16'd1, 10'd516),
      make_event(CMD_PACKET, 16'h0000, OP_DATA, 16'd1, 10'd516),
      make_event(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF),
      make_event(CMD_START,  16'hFFFF, 16'h0000, 16'h0000, 10'd0),
      make_event(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000, 10'd0),
      make_event(CMD_PACKET, 16'h0000, OP_DATA, 16'd1, 10'd516),
      make_event(CMD_PACKET, 16'hFFFF, OP_ACK, 16'd1, 10'd516),
      make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd1, 10'd3),
      make_event(CMD_PACKET, 16'hFFFF, 16'hFFFF, 16'd1, 10'd0),
      make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd2, 10'd516),
      make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd1, 10'd516),
      make_event(CMD_TICK,   16'hFFFF, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd1, 10'd516),
      make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd2, 10'h3FF),
      make_event(CMD_PACKET, 16'hFFFF, OP_DATA, 16'd3, 10'd4),
      make_event(CMD_TICK,   16'hFFFF, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_START,  16'h0000, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_START,  16'h8001, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_PACKET, 16'h0000, OP_DATA, 16'd1, 10'd516),
      make_event(CMD_PACKET, 16'h8001, OP_DATA, LAST_BLOCK, 10'd516),
      make_event(CMD_START,  16'h1234, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_TICK,   16'h1234, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_TICK,   16'h1234, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_TICK,   16'h1234, OP_DATA, 16'd0, 10'd0),
      make_event(CMD_PACKET, 16'h1234, OP_DATA, 16'd1, 10'd100)
    };
    foreach (directed[i]) send_event(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      apply_setting(tries_seq[p]);
      in_idle_pct   = idle_in[p % 4];
      out_stall_pct = stall_out[p % 4];
      n = 0;
      while (n < PHASE_ITEMS) begin
        ev = random_event();
        send_event(ev);
        n++;
      end
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    drain();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d event beats over %0d tick-limit settings and four idling mixes.",
             predictor.events, PHASES + 1);
    $display("Replies %0d, stores %0d, completed %0d, aborted %0d, %0d mismatches.",
             predictor.replies, predictor.stores, predictor.completions,
             predictor.aborts, predictor.mismatches);
    if (predictor.mismatches == 0 && predictor.expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5ms);
    $display("TEST FAILED");
    $finish;
  end

endmodule
